// ===== rtl/rqs_pkg.sv =====
// rqs_pkg: shared constants, types and state codes for the record quicksort unit
// no dependencies
package rqs_pkg;

  localparam int MaxRecords  = 64;
  localparam int PayloadBits = 32;
  localparam int KeyBits     = 8;
  localparam int IdxBits     = (MaxRecords > 1) ? $clog2(MaxRecords) : 1;
  localparam int CntBits     = $clog2(MaxRecords + 1);
  localparam int RecBits     = KeyBits + PayloadBits;
  localparam int StkBits     = 2 * IdxBits;

  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef struct packed {
    logic [KeyBits-1:0]     key;
    logic [PayloadBits-1:0] data;
  } rec_t;

  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_POP,
    S_POP_WAIT,
    S_PIV_RD,
    S_PIV_WAIT,
    S_I_RD,
    S_I_WAIT,
    S_J_RD,
    S_J_WAIT,
    S_SW_WR1,
    S_SW_WR2,
    S_FIN_RD,
    S_FIN_WAIT,
    S_FIN_WR1,
    S_FIN_WR2,
    S_PUSH_HI,
    S_PUSH_LO,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_EMIT_OUT
  } state_t;

  // memory access bundle from sequencer to the record store
  typedef struct packed {
    logic we;
    idx_t addr;
    rec_t wdata;
  } rec_req_t;

endpackage

// ===== rtl/rqs_ram.sv =====
// rqs_ram: generic single-port synchronous ram with registered read
// no dependencies
module rqs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/rqs_seq.sv =====
// rqs_seq: load, partition and emit sequencer driving the record and range memories
// depends on rqs_pkg and rqs_ram
module rqs_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rqs_pkg::rec_t                in_rec,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rqs_pkg::rec_t                out_rec,
  output logic                         out_last,
  output logic                         out_ovf
);

  rqs_pkg::state_t state_r, state_nxt;
  rqs_pkg::cnt_t   count_r, count_nxt;
  rqs_pkg::cnt_t   sp_r, sp_nxt;
  logic            ovf_r, ovf_nxt;
  rqs_pkg::idx_t   lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, j_r, j_nxt;
  rqs_pkg::idx_t   k_r, k_nxt;
  logic [rqs_pkg::KeyBits-1:0] piv_r, piv_nxt;
  rqs_pkg::rec_t   reci_r, reci_nxt, recj_r, recj_nxt;
  logic            ov_r, ov_nxt, ol_r, ol_nxt, ovo_r, ovo_nxt;
  rqs_pkg::rec_t   orec_r, orec_nxt;

  rqs_pkg::rec_req_t rq;
  rqs_pkg::rec_t     rd;
  logic              s_we;
  rqs_pkg::idx_t     s_addr;
  rqs_pkg::range_t   s_wd, s_rd;

  rqs_ram #(.Width(rqs_pkg::RecBits), .Depth(rqs_pkg::MaxRecords)) u_store (
    .clk(clk), .we(rq.we), .addr(rq.addr), .wdata(rq.wdata), .rdata(rd)
  );
  rqs_ram #(.Width(rqs_pkg::StkBits), .Depth(rqs_pkg::MaxRecords)) u_stack (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqs_pkg::S_LOAD;
      count_r <= '0;
      sp_r    <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sp_r    <= sp_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    piv_r <= piv_nxt; reci_r <= reci_nxt; recj_r <= recj_nxt;
    ol_r <= ol_nxt; ovo_r <= ovo_nxt; orec_r <= orec_nxt;
  end

  assign in_ready  = (state_r == rqs_pkg::S_LOAD);
  assign out_valid = ov_r;
  assign out_rec   = orec_r;
  assign out_last  = ol_r;
  assign out_ovf   = ovo_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; sp_nxt = sp_r; ovf_nxt = ovf_r;
    lo_nxt = lo_r; hi_nxt = hi_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    piv_nxt = piv_r; reci_nxt = reci_r; recj_nxt = recj_r;
    ov_nxt = ov_r; ol_nxt = ol_r; ovo_nxt = ovo_r; orec_nxt = orec_r;
    rq = '0; s_we = 1'b0; s_addr = sp_r[rqs_pkg::IdxBits-1:0]; s_wd = '0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      rqs_pkg::S_LOAD: begin
        if (in_valid) begin
          if (count_r < rqs_pkg::CntBits'(rqs_pkg::MaxRecords)) begin
            rq.we = 1'b1; rq.addr = count_r[rqs_pkg::IdxBits-1:0]; rq.wdata = in_rec;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            k_nxt = '0;
            // push whole range if two or more records
            if (count_nxt > rqs_pkg::CntBits'(1)) begin
              s_we = 1'b1; s_addr = '0;
              s_wd.lo = '0;
              s_wd.hi = rqs_pkg::IdxBits'(count_nxt - 1'b1);
              sp_nxt = rqs_pkg::CntBits'(1);
              state_nxt = rqs_pkg::S_POP;
            end else if (count_nxt == '0) begin
              ovf_nxt = 1'b0;
              state_nxt = rqs_pkg::S_LOAD;
            end else begin
              state_nxt = rqs_pkg::S_EMIT_RD;
            end
          end
        end
      end
      rqs_pkg::S_POP: begin
        if (sp_r == '0) begin
          state_nxt = rqs_pkg::S_EMIT_RD;
        end else begin
          sp_nxt = sp_r - 1'b1;
          s_addr = rqs_pkg::IdxBits'(sp_r - 1'b1);
          state_nxt = rqs_pkg::S_POP_WAIT;
        end
      end
      rqs_pkg::S_POP_WAIT: begin
        lo_nxt = s_rd.lo; hi_nxt = s_rd.hi;
        rq.addr = s_rd.hi;
        state_nxt = rqs_pkg::S_PIV_WAIT;
      end
      rqs_pkg::S_PIV_RD: begin
        rq.addr = hi_r;
        state_nxt = rqs_pkg::S_PIV_WAIT;
      end
      rqs_pkg::S_PIV_WAIT: begin
        piv_nxt = rd.key;
        recj_nxt = rd;
        i_nxt = lo_r; j_nxt = hi_r;
        rq.addr = lo_r;
        state_nxt = rqs_pkg::S_I_WAIT;
      end
      rqs_pkg::S_I_RD: begin
        rq.addr = i_r;
        state_nxt = rqs_pkg::S_I_WAIT;
      end
      rqs_pkg::S_I_WAIT: begin
        // left scan stops at first key not below the pivot (pivot bounds it)
        if (rd.key < piv_r) begin
          i_nxt = i_r + 1'b1;
          rq.addr = i_r + 1'b1;
        end else begin
          reci_nxt = rd;
          j_nxt = j_r - 1'b1;
          rq.addr = j_r - 1'b1;
          state_nxt = rqs_pkg::S_J_WAIT;
        end
      end
      rqs_pkg::S_J_RD: begin
        rq.addr = j_r;
        state_nxt = rqs_pkg::S_J_WAIT;
      end
      rqs_pkg::S_J_WAIT: begin
        if (rd.key > piv_r && j_r != lo_r) begin
          j_nxt = j_r - 1'b1;
          rq.addr = j_r - 1'b1;
        end else if (i_r >= j_r) begin
          // pivot record sits at hi: swap i with hi
          rq.addr = hi_r;
          state_nxt = rqs_pkg::S_FIN_WAIT;
        end else begin
          recj_nxt = rd;
          state_nxt = rqs_pkg::S_SW_WR1;
        end
      end
      rqs_pkg::S_SW_WR1: begin
        rq.we = 1'b1; rq.addr = i_r; rq.wdata = recj_r;
        state_nxt = rqs_pkg::S_SW_WR2;
      end
      rqs_pkg::S_SW_WR2: begin
        rq.we = 1'b1; rq.addr = j_r; rq.wdata = reci_r;
        i_nxt = i_r + 1'b1;
        state_nxt = rqs_pkg::S_I_RD;
      end
      rqs_pkg::S_FIN_RD: begin
        rq.addr = hi_r;
        state_nxt = rqs_pkg::S_FIN_WAIT;
      end
      rqs_pkg::S_FIN_WAIT: begin
        recj_nxt = rd;
        state_nxt = rqs_pkg::S_FIN_WR1;
      end
      rqs_pkg::S_FIN_WR1: begin
        rq.we = 1'b1; rq.addr = i_r; rq.wdata = recj_r;
        state_nxt = rqs_pkg::S_FIN_WR2;
      end
      rqs_pkg::S_FIN_WR2: begin
        rq.we = 1'b1; rq.addr = hi_r; rq.wdata = reci_r;
        state_nxt = rqs_pkg::S_PUSH_HI;
      end
      rqs_pkg::S_PUSH_HI: begin
        if (hi_r > i_r + 1'b1 && i_r != hi_r) begin
          s_we = 1'b1; s_wd.lo = i_r + 1'b1; s_wd.hi = hi_r;
          sp_nxt = sp_r + 1'b1;
        end
        state_nxt = rqs_pkg::S_PUSH_LO;
      end
      rqs_pkg::S_PUSH_LO: begin
        if (i_r != '0 && (i_r - 1'b1) > lo_r && i_r > lo_r) begin
          s_we = 1'b1; s_wd.lo = lo_r; s_wd.hi = i_r - 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
        state_nxt = rqs_pkg::S_POP;
      end
      rqs_pkg::S_EMIT_RD: begin
        rq.addr = k_r;
        state_nxt = rqs_pkg::S_EMIT_WAIT;
      end
      rqs_pkg::S_EMIT_WAIT: begin
        // keep the address so the read data stays on record k
        rq.addr = k_r;
        state_nxt = rqs_pkg::S_EMIT_OUT;
      end
      rqs_pkg::S_EMIT_OUT: begin
        rq.addr = k_r;
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; orec_nxt = rd; ovo_nxt = ovf_r;
          ol_nxt = (rqs_pkg::CntBits'(k_r) + 1'b1 == count_r);
          if (ol_nxt) begin
            count_nxt = '0; sp_nxt = '0; ovf_nxt = 1'b0;
            state_nxt = rqs_pkg::S_LOAD;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = rqs_pkg::S_EMIT_RD;
          end
        end
      end
      default: state_nxt = rqs_pkg::S_LOAD;
    endcase
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= rqs_pkg::CntBits'(rqs_pkg::MaxRecords)) else $error("range stack overrun");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rqs_pkg::CntBits'(rqs_pkg::MaxRecords)) else $error("record count overrun");
  a_no_load_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rqs_pkg::S_LOAD) |-> !in_ready) else $error("input taken while sorting");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_nxt && ol_nxt && !ov_r) |=> (count_r == '0)) else $error("count kept after set");

endmodule

// ===== rtl/record_quicksort_by_key_unit.sv =====
// record_quicksort_by_key_unit: top level of the record quicksort unit
// depends on rqs_pkg and rqs_seq (which holds the rqs_ram instances)
//
// Collects up to 64 records (8-bit key, 32-bit payload), one word per cycle,
// into a single-port record ram; the word with tlast closes the set. The set is
// then sorted ascending by key with a last-element-pivot quicksort whose pending
// ranges live on a second ram used as a stack, and finally every record leaves
// in order, tlast on the final one and tuser set on all if words beyond capacity
// were dropped. Input is stalled from the closing word until the last result is
// placed on the output. Sorting is bound by the one read-or-write port of the
// record ram, and each record is emitted in a read, a wait and an output step.
module record_quicksort_by_key_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key_age[7:0], payload[39:8]
  input  logic        in_tlast,   // last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // sorted_age[7:0], sorted_payload[39:8]
  output logic        out_tlast,  // last_result
  output logic        out_tuser   // overflow
);

  rqs_pkg::rec_t in_rec, out_rec;

  // word layout puts key low, so reorder into the record struct
  assign in_rec.key  = in_tdata[7:0];
  assign in_rec.data = in_tdata[39:8];

  rqs_seq u_seq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_rec(in_rec), .in_last(in_tlast),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_rec(out_rec),
    .out_last(out_tlast), .out_ovf(out_tuser)
  );

  assign out_tdata = {out_rec.data, out_rec.key};

endmodule
